### rtl/pcrg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pcrg_pkg;

  localparam int REG_BITS   = 63;
  localparam int INDEX_BITS = 8;
  localparam int LANES      = 3;
  localparam int Q_BITS     = 16;
  localparam int A_BITS     = 15;
  localparam int SQ_BITS    = 2 * A_BITS;
  localparam int SUM_BITS   = 32;
  localparam int REM_BITS   = 64;
  localparam int QS_BITS    = Q_BITS + SUM_BITS;

  localparam logic [INDEX_BITS-1:0] REG_CAMERA_POSITION    = 8'd0;
  localparam logic [INDEX_BITS-1:0] REG_FIRST_PIXEL_CENTER = 8'd1;
  localparam logic [INDEX_BITS-1:0] REG_STEP_PER_COLUMN    = 8'd2;
  localparam logic [INDEX_BITS-1:0] REG_STEP_PER_ROW       = 8'd3;

  typedef struct packed {
    logic [15:0] pixel_column;
    logic [15:0] pixel_row;
  } pixel_t;

  typedef struct packed {
    logic signed [15:0] direction_x;
    logic signed [15:0] direction_y;
    logic signed [15:0] direction_z;
  } result_t;

  typedef struct packed {
    logic                neg;
    logic [Q_BITS-1:0]   q;
    logic [REM_BITS-1:0] rem;
    logic [QS_BITS-1:0]  qs;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0]   lane;
    logic [SUM_BITS-1:0] s;
    logic                zero;
  } stage_t;

endpackage
`default_nettype wire

### rtl/pcrg_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pcrg_front #(
  parameter int PIXEL_FRAC_BITS = 4,
  parameter int COMPONENT_BITS  = 21
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire pcrg_pkg::pixel_t              pixel,
  input  wire logic [pcrg_pkg::REG_BITS-1:0] camera_position,
  input  wire logic [pcrg_pkg::REG_BITS-1:0] first_pixel_center,
  input  wire logic [pcrg_pkg::REG_BITS-1:0] step_per_column,
  input  wire logic [pcrg_pkg::REG_BITS-1:0] step_per_row,
  output logic                               out_valid,
  output pcrg_pkg::stage_t                   out_stage
);

  localparam int CB  = COMPONENT_BITS;
  localparam int PW  = CB + 17;
  localparam int DW  = CB + 20;
  localparam int SHW = $clog2(DW);
  localparam int L   = pcrg_pkg::LANES;

  logic [6:0] valid;

  logic signed [DW-1:0] base   [L];
  logic signed [DW-1:0] base1  [L];
  logic signed [PW-1:0] pcol1  [L];
  logic signed [PW-1:0] prow1  [L];
  logic signed [DW-1:0] d2     [L];
  logic [DW-1:0]        mag3   [L];
  logic [L-1:0]         neg3;
  logic [DW-1:0]        max3;
  logic [DW-1:0]        max_c;
  logic [DW-1:0]        mag4   [L];
  logic [L-1:0]         neg4;
  logic                 zero4;
  logic [SHW-1:0]       sh4;
  logic [SHW-1:0]       sh_c;
  logic [pcrg_pkg::A_BITS-1:0]  a5 [L];
  logic [L-1:0]                 neg5;
  logic                         zero5;
  logic [pcrg_pkg::SQ_BITS-1:0] sq6 [L];
  logic [L-1:0]                 neg6;
  logic                         zero6;
  pcrg_pkg::stage_t             stage7;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[5:0], in_valid};
    end
  end

  always_comb begin
    for (int i = 0; i < L; i++) begin
      base[i] = (DW'($signed(first_pixel_center[i*CB +: CB]))
                - DW'($signed(camera_position[i*CB +: CB]))) <<< PIXEL_FRAC_BITS;
    end
  end

  // products and base offset
  always_ff @(posedge clk) begin
    for (int i = 0; i < L; i++) begin
      base1[i] <= base[i];
      pcol1[i] <= $signed({1'b0, pixel.pixel_column}) * $signed(step_per_column[i*CB +: CB]);
      prow1[i] <= $signed({1'b0, pixel.pixel_row}) * $signed(step_per_row[i*CB +: CB]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < L; i++) begin
      d2[i] <= base1[i] + DW'(pcol1[i]) + DW'(prow1[i]);
    end
  end

  always_comb begin
    max_c = '0;
    for (int i = 0; i < L; i++) begin
      if ((d2[i][DW-1] ? DW'(-d2[i]) : DW'(d2[i])) > max_c) begin
        max_c = d2[i][DW-1] ? DW'(-d2[i]) : DW'(d2[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < L; i++) begin
      neg3[i] <= d2[i][DW-1];
      mag3[i] <= d2[i][DW-1] ? DW'(-d2[i]) : DW'(d2[i]);
    end
    max3 <= max_c;
  end

  // smallest shift that brings the largest magnitude below 2^15
  always_comb begin
    sh_c = '0;
    for (int b = pcrg_pkg::A_BITS; b < DW; b++) begin
      if (max3[b]) begin
        sh_c = SHW'(b - pcrg_pkg::A_BITS + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    mag4  <= mag3;
    neg4  <= neg3;
    zero4 <= (max3 == '0);
    sh4   <= sh_c;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < L; i++) begin
      a5[i] <= pcrg_pkg::A_BITS'(mag4[i] >> sh4);
    end
    neg5  <= neg4;
    zero5 <= zero4;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < L; i++) begin
      sq6[i] <= a5[i] * a5[i];
    end
    neg6  <= neg5;
    zero6 <= zero5;
  end

  always_ff @(posedge clk) begin
    stage7.s    <= pcrg_pkg::SUM_BITS'(sq6[0]) + pcrg_pkg::SUM_BITS'(sq6[1])
                 + pcrg_pkg::SUM_BITS'(sq6[2]);
    stage7.zero <= zero6;
    for (int i = 0; i < L; i++) begin
      stage7.lane[i].neg <= neg6[i];
      stage7.lane[i].q   <= '0;
      stage7.lane[i].qs  <= '0;
      stage7.lane[i].rem <= pcrg_pkg::REM_BITS'(sq6[i]) << 30;
    end
  end

  assign out_valid = valid[6];
  assign out_stage = stage7;

endmodule
`default_nettype wire

### rtl/pcrg_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module pcrg_cell #(
  parameter int BIT = 15
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire pcrg_pkg::stage_t in_stage,
  output logic                  out_valid,
  output pcrg_pkg::stage_t      out_stage
);

  localparam int DLW = pcrg_pkg::REM_BITS + 16;

  logic [DLW-1:0]   delta [pcrg_pkg::LANES];
  pcrg_pkg::stage_t nxt;

  // try bit: (q + 2^b)^2 s - q^2 s = 2^(b+1) qs + 2^(2b) s
  always_comb begin
    nxt = in_stage;
    for (int i = 0; i < pcrg_pkg::LANES; i++) begin
      delta[i] = (DLW'(in_stage.lane[i].qs) << (BIT + 1))
               + (DLW'(in_stage.s) << (2 * BIT));
      if (delta[i] <= DLW'(in_stage.lane[i].rem)) begin
        nxt.lane[i].rem    = in_stage.lane[i].rem - pcrg_pkg::REM_BITS'(delta[i]);
        nxt.lane[i].qs     = in_stage.lane[i].qs
                           + (pcrg_pkg::QS_BITS'(in_stage.s) << BIT);
        nxt.lane[i].q[BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_stage <= nxt;
  end

endmodule
`default_nettype wire

### rtl/pinhole_camera_ray_generator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Pinhole camera ray generator: pixel position in, unit ray direction out.
// Command channel: pixel is taken at a clock edge where start is high and
// busy is low. busy is always low, so a new pixel may come every cycle.
// Result channel: result_valid is high for one cycle with the Q1.15
// direction on result; the receiver cannot stall and must take it then.
// The pipeline has 7 front stages (multiply, sum, magnitude, shift
// search, shift, square, sum of squares), 16 cells of the division chain
// (one quotient bit per cell, three components side by side) and the
// output register. Throughput is one transaction per cycle.
// Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high;
// index 0 camera_position, 1 first_pixel_center, 2 step_per_column,
// 3 step_per_row, other indexes are dropped. Write only while idle.
// Reset zeroes config registers and valid bits, emptying the pipeline.
module pinhole_camera_ray_generator_unit #(
  parameter int PIXEL_FRAC_BITS = 4,
  parameter int COMPONENT_BITS  = 21
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire pcrg_pkg::pixel_t                pixel,
  output logic                                 result_valid,
  output pcrg_pkg::result_t                    result,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pcrg_pkg::INDEX_BITS-1:0] cfg_index,
  input  wire logic [pcrg_pkg::REG_BITS-1:0]   cfg_data
);

  localparam int NC = pcrg_pkg::Q_BITS;

  logic [pcrg_pkg::REG_BITS-1:0] camera_position;
  logic [pcrg_pkg::REG_BITS-1:0] first_pixel_center;
  logic [pcrg_pkg::REG_BITS-1:0] step_per_column;
  logic [pcrg_pkg::REG_BITS-1:0] step_per_row;

  logic             chain_valid [NC+1];
  pcrg_pkg::stage_t chain_stage [NC+1];
  logic [15:0]      mag [pcrg_pkg::LANES];
  logic [15:0]      dir [pcrg_pkg::LANES];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      camera_position    <= '0;
      first_pixel_center <= '0;
      step_per_column    <= '0;
      step_per_row       <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pcrg_pkg::REG_CAMERA_POSITION:    camera_position    <= cfg_data;
        pcrg_pkg::REG_FIRST_PIXEL_CENTER: first_pixel_center <= cfg_data;
        pcrg_pkg::REG_STEP_PER_COLUMN:    step_per_column    <= cfg_data;
        pcrg_pkg::REG_STEP_PER_ROW:       step_per_row       <= cfg_data;
        default: ;
      endcase
    end
  end

  pcrg_front #(
    .PIXEL_FRAC_BITS(PIXEL_FRAC_BITS),
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (start),
    .pixel             (pixel),
    .camera_position   (camera_position),
    .first_pixel_center(first_pixel_center),
    .step_per_column   (step_per_column),
    .step_per_row      (step_per_row),
    .out_valid         (chain_valid[0]),
    .out_stage         (chain_stage[0])
  );

  for (genvar c = 0; c < NC; c++) begin : g_cell
    pcrg_cell #(
      .BIT(NC - 1 - c)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (chain_valid[c]),
      .in_stage (chain_stage[c]),
      .out_valid(chain_valid[c+1]),
      .out_stage(chain_stage[c+1])
    );
  end

  // clamp full length to 32767, apply sign, force zero for a null vector
  always_comb begin
    for (int i = 0; i < pcrg_pkg::LANES; i++) begin
      mag[i] = chain_stage[NC].lane[i].q[15] ? 16'h7fff : chain_stage[NC].lane[i].q;
      if (chain_stage[NC].zero) begin
        dir[i] = '0;
      end else if (chain_stage[NC].lane[i].neg) begin
        dir[i] = 16'd0 - mag[i];
      end else begin
        dir[i] = mag[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= chain_valid[NC];
    end
  end

  always_ff @(posedge clk) begin
    result.direction_x <= $signed(dir[0]);
    result.direction_y <= $signed(dir[1]);
    result.direction_z <= $signed(dir[2]);
  end

endmodule
`default_nettype wire
